// ===== design/mms_pkg.sv =====
package mms_pkg;

	localparam int MAX_DIM  = 64;
	localparam int MAX_ROWS = 4096;

	localparam int DIM_W  = $clog2(MAX_DIM);
	localparam int CNT_W  = $clog2(MAX_DIM + 1);
	localparam int ROWS_W = $clog2(MAX_ROWS + 1);
	localparam int ROW_W  = 12;
	localparam int COL_W  = 6;
	localparam int ELEM_W = 16;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int ACC_W  = 48;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = ROWS_W;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B     = 2'd2;

	localparam logic KIND_B_WRITE = 1'b0;
	localparam logic KIND_A_ELEM  = 1'b1;

	localparam int S_TDATA_W  = 40;
	localparam int S_PAD_W    = S_TDATA_W - (ROW_W + COL_W + ELEM_W);
	localparam int M_TDATA_W  = 72;
	localparam int M_PAD_W    = M_TDATA_W - (ROW_W + COL_W + ACC_W);

	localparam int CMDQ_DEPTH = 2;
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

	typedef enum logic {
		OP_B_WRITE,
		OP_A_ELEM
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [ELEM_W-1:0] value;
		logic              emit;
		logic              last_row;
		logic [CNT_W-1:0]  count;
	} cmd_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [ACC_W-1:0] value;
		logic             last;
		logic             done;
	} res_t;

endpackage

// ===== design/mms_fifo.sv =====
module mms_fifo
	import mms_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             push_data,
	output logic                         full,
	input  logic                         pop,
	output logic [WIDTH-1:0]             pop_data,
	output logic                         not_empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign count     = count_q;
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/mms_front.sv =====
module mms_front
	import mms_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_kind,
	input  logic [ROW_W-1:0]      in_row,
	input  logic [COL_W-1:0]      in_col,
	input  logic [ELEM_W-1:0]     in_value,
	output logic                  cmd_push,
	output cmd_t                  cmd_data,
	input  logic                  cmd_full
);

	logic [ROWS_W-1:0] rows_a_q;
	logic [CNT_W-1:0]  inner_q;
	logic [CNT_W-1:0]  cols_q;
	logic [ROWS_W-1:0] nr;
	logic [CNT_W-1:0]  nk;
	logic [CNT_W-1:0]  nc;
	logic [ROWS_W-1:0] row_ext;
	logic [ROWS_W-1:0] col_ext;
	logic              keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= ROWS_W'(64);
			inner_q  <= CNT_W'(64);
			cols_q   <= CNT_W'(64);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROWS_A:     rows_a_q <= cfg_data;
				REG_INNER_SIZE: inner_q  <= cfg_data[CNT_W-1:0];
				REG_COLS_B:     cols_q   <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register values of zero act as one, values above the maximum as the maximum.
	always_comb begin
		if (rows_a_q == '0) begin
			nr = ROWS_W'(1);
		end else if (rows_a_q > ROWS_W'(MAX_ROWS)) begin
			nr = ROWS_W'(MAX_ROWS);
		end else begin
			nr = rows_a_q;
		end
		if (inner_q == '0) begin
			nk = CNT_W'(1);
		end else if (inner_q > CNT_W'(MAX_DIM)) begin
			nk = CNT_W'(MAX_DIM);
		end else begin
			nk = inner_q;
		end
		if (cols_q == '0) begin
			nc = CNT_W'(1);
		end else if (cols_q > CNT_W'(MAX_DIM)) begin
			nc = CNT_W'(MAX_DIM);
		end else begin
			nc = cols_q;
		end
	end

	assign row_ext = ROWS_W'(in_row);
	assign col_ext = ROWS_W'(in_col);

	always_comb begin
		cmd_data.row      = in_row;
		cmd_data.col      = in_col;
		cmd_data.value    = in_value;
		cmd_data.count    = nc;
		cmd_data.emit     = (CNT_W'(in_col) == nk - CNT_W'(1));
		cmd_data.last_row = (row_ext == nr - ROWS_W'(1));
		unique case (in_kind)
			KIND_B_WRITE: begin
				cmd_data.op = OP_B_WRITE;
				keep        = (row_ext < ROWS_W'(nk)) && (col_ext < ROWS_W'(nc));
			end
			KIND_A_ELEM: begin
				cmd_data.op = OP_A_ELEM;
				keep        = (row_ext < nr) && (col_ext < ROWS_W'(nk));
			end
			default: begin
				cmd_data.op = OP_B_WRITE;
				keep        = 1'b0;
			end
		endcase
	end

	// Requests with an index out of range are taken and dropped here.
	assign in_ready = !cmd_full;
	assign cmd_push = in_valid && in_ready && keep;

endmodule

// ===== design/mms_back.sv =====
module mms_back
	import mms_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_pop,
	input  cmd_t                  cmd_data,
	output logic                  res_push,
	output res_t                  res_data,
	input  logic [OUTQ_CNT_W-1:0] res_count
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t                    state_q;
	cmd_t                      cmd_q;
	logic [CNT_W-1:0]          j_q;
	logic [MAX_DIM-1:0]        acc_vld_q;

	logic [ELEM_W-1:0]         b_mem [MAX_DIM * MAX_DIM];
	logic [ACC_W-1:0]          acc_mem [MAX_DIM];

	logic                      vld_s1;
	logic                      vld_s2;
	logic [ELEM_W-1:0]         b_rd_s1;
	logic [ACC_W-1:0]          acc_rd_s1;
	logic                      accv_s1;
	logic [DIM_W-1:0]          j_s1;
	logic signed [PROD_W-1:0]  prod_s2;
	logic [ACC_W-1:0]          acc_s2;
	logic [DIM_W-1:0]          j_s2;

	logic                      em_vld_s1;
	logic                      em_last_s1;
	logic                      em_done_s1;
	logic [ROW_W-1:0]          em_row_s1;

	logic [DIM_W-1:0]          j_idx;
	logic                      last_j;
	logic                      b_we;
	logic [2*DIM_W-1:0]        b_waddr;
	logic [2*DIM_W-1:0]        b_raddr;
	logic [ACC_W-1:0]          acc_sum;
	logic [OUTQ_CNT_W:0]       out_used;
	logic                      em_issue;

	assign j_idx    = j_q[DIM_W-1:0];
	assign last_j   = (j_q == cmd_q.count - CNT_W'(1));
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign b_we     = cmd_pop && (cmd_data.op == OP_B_WRITE);
	assign b_waddr  = {cmd_data.row[DIM_W-1:0], cmd_data.col[DIM_W-1:0]};
	assign b_raddr  = {cmd_q.col[DIM_W-1:0], j_idx};
	assign acc_sum  = acc_s2 + {{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
	assign out_used = {1'b0, res_count} + (OUTQ_CNT_W + 1)'(em_vld_s1);
	assign em_issue = (state_q == ST_EMIT) && (out_used < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));

	always_ff @(posedge clk) begin
		if (b_we) begin
			b_mem[b_waddr] <= cmd_data.value;
		end
		b_rd_s1 <= b_mem[b_raddr];
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			acc_mem[j_s2] <= acc_sum;
		end
		acc_rd_s1 <= acc_mem[j_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd_data;
		end
		accv_s1    <= acc_vld_q[j_idx];
		j_s1       <= j_idx;
		prod_s2    <= $signed(cmd_q.value) * $signed(b_rd_s1);
		acc_s2     <= accv_s1 ? acc_rd_s1 : '0;
		j_s2       <= j_s1;
		em_last_s1 <= last_j;
		em_done_s1 <= last_j && cmd_q.last_row;
		em_row_s1  <= cmd_q.row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			j_q       <= '0;
			acc_vld_q <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			em_vld_s1 <= 1'b0;
		end else begin
			vld_s1    <= (state_q == ST_MAC);
			vld_s2    <= vld_s1;
			em_vld_s1 <= em_issue;
			if (vld_s2) begin
				acc_vld_q[j_s2] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop && (cmd_data.op == OP_A_ELEM)) begin
						state_q <= ST_MAC;
						j_q     <= '0;
					end
				end
				ST_MAC: begin
					j_q <= j_q + 1'b1;
					if (last_j) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!vld_s1 && !vld_s2) begin
						j_q     <= '0;
						state_q <= cmd_q.emit ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (em_issue) begin
						j_q <= j_q + 1'b1;
						if (last_j) begin
							acc_vld_q <= '0;
							state_q   <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_push       = em_vld_s1;
	assign res_data.row   = em_row_s1;
	assign res_data.col   = COL_W'(j_s1);
	assign res_data.value = accv_s1 ? acc_rd_s1 : '0;
	assign res_data.last  = em_last_s1;
	assign res_data.done  = em_done_s1;

endmodule

// ===== design/matrix_multiply_stream_core.sv =====
// A B element request is written to B memory as it is taken; an A element runs one
// multiply-accumulate per column through the single MAC unit and B memory port.
// The element that closes a row adds cols_b results of output at one result per cycle
// while the output is taken. Reset clears the control state and the accumulator valid
// flags and sets the registers to 64.
module matrix_multiply_stream_core
	import mms_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // row_index, col_index, elem_value, zero fill
	input  logic                  s_tuser,  // kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,  // out_row, out_col, out_value, zero fill
	output logic                  m_tlast,
	output logic                  m_tuser   // matrix_done
);

	cmd_t                  front_cmd;
	logic                  front_push;
	logic                  cmdq_full;
	logic [$bits(cmd_t)-1:0] cmdq_rd;
	logic                  cmdq_valid;
	logic [$clog2(CMDQ_DEPTH + 1)-1:0] cmdq_count;
	logic                  cmd_pop;
	res_t                  res_in;
	logic                  res_push;
	logic                  resq_full;
	logic [$bits(res_t)-1:0] resq_rd;
	logic [OUTQ_CNT_W-1:0] resq_count;
	res_t                  res_out;

	assign cfg_ready = 1'b1;

	mms_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_kind  (s_tuser),
		.in_row   (s_tdata[ROW_W-1:0]),
		.in_col   (s_tdata[ROW_W+COL_W-1:ROW_W]),
		.in_value (s_tdata[ROW_W+COL_W+ELEM_W-1:ROW_W+COL_W]),
		.cmd_push (front_push),
		.cmd_data (front_cmd),
		.cmd_full (cmdq_full)
	);

	mms_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMDQ_DEPTH)
	) u_cmd_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_push),
		.push_data(front_cmd),
		.full     (cmdq_full),
		.pop      (cmd_pop),
		.pop_data (cmdq_rd),
		.not_empty(cmdq_valid),
		.count    (cmdq_count)
	);

	mms_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmdq_valid),
		.cmd_pop  (cmd_pop),
		.cmd_data (cmd_t'(cmdq_rd)),
		.res_push (res_push),
		.res_data (res_in),
		.res_count(resq_count)
	);

	mms_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(OUTQ_DEPTH)
	) u_res_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_push),
		.push_data(res_in),
		.full     (resq_full),
		.pop      (m_tready),
		.pop_data (resq_rd),
		.not_empty(m_tvalid),
		.count    (resq_count)
	);

	assign res_out = res_t'(resq_rd);
	assign m_tdata = {{M_PAD_W{1'b0}}, res_out.value, res_out.col, res_out.row};
	assign m_tlast = res_out.last;
	assign m_tuser = res_out.done;

	assert property (@(posedge clk) disable iff (!arst_n) res_push |-> !resq_full)
		else $error("Result pushed into a full output queue.");

	assert property (@(posedge clk) disable iff (!arst_n) (m_tvalid && m_tuser) |-> m_tlast)
		else $error("Matrix end flagged on a result that does not close its row.");

	assert property (@(posedge clk) disable iff (!arst_n) front_push |-> !cmdq_full)
		else $error("Request pushed into a full command queue.");

	assert property (@(posedge clk) disable iff (!arst_n) (cmdq_count == '0) |-> !cmd_pop)
		else $error("Request taken from an empty command queue.");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import mms_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam int DRAIN_CYCLES = 300;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 5000;
	localparam int RANDOM_ITEMS = 230;

	class mm_scoreboard;
		logic [ELEM_W-1:0] b_mem [MAX_DIM*MAX_DIM];
		bit                b_written [MAX_DIM*MAX_DIM];
		logic [ACC_W-1:0]  col_acc [MAX_DIM];
		logic [ROWS_W-1:0] rows_reg;
		logic [CNT_W-1:0]  inner_reg;
		logic [CNT_W-1:0]  cols_reg;
		res_t              expected_c [$];
		int                errors;

		function new();
			rows_reg  = 64;
			inner_reg = 64;
			cols_reg  = 64;
			errors    = 0;
			foreach (col_acc[n])
				col_acc[n] = '0;
			foreach (b_written[n])
				b_written[n] = 1'b0;
		endfunction

		function int clamp_dim(int v, int hi);
			if (v == 0)
				return 1;
			return (v > hi) ? hi : v;
		endfunction

		function int num_rows();
			return clamp_dim(int'(rows_reg), MAX_ROWS);
		endfunction

		function int num_inner();
			return clamp_dim(int'(inner_reg), MAX_DIM);
		endfunction

		function int num_cols();
			return clamp_dim(int'(cols_reg), MAX_DIM);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ROWS_A: rows_reg = data;
				REG_INNER_SIZE: inner_reg = data[CNT_W-1:0];
				REG_COLS_B: cols_reg = data[CNT_W-1:0];
				default: ;
			endcase
		endfunction

		// Returns whether the block acts on the request at all.
		function bit note_element(op_t kind, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
				logic [ELEM_W-1:0] value);
			int nr, nk, nc, j;
			logic signed [PROD_W-1:0] prod;
			res_t r;
			nr = num_rows();
			nk = num_inner();
			nc = num_cols();
			if (kind == OP_B_WRITE) begin
				if (int'(row) >= nk || int'(col) >= nc)
					return 1'b0;
				b_mem[{row[DIM_W-1:0], col}] = value;
				b_written[{row[DIM_W-1:0], col}] = 1'b1;
				return 1'b1;
			end
			if (int'(row) >= nr || int'(col) >= nk)
				return 1'b0;
			for (j = 0; j < nc; j++) begin
				prod = $signed(value) * $signed(b_mem[{col, DIM_W'(j)}]);
				col_acc[DIM_W'(j)] = col_acc[DIM_W'(j)] +
					{{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
			end
			if (int'(col) == nk - 1) begin
				for (j = 0; j < nc; j++) begin
					r.row   = row;
					r.col   = COL_W'(j);
					r.value = col_acc[DIM_W'(j)];
					r.last  = (j == nc - 1);
					r.done  = r.last && (int'(row) == nr - 1);
					expected_c.push_back(r);
				end
				foreach (col_acc[n])
					col_acc[n] = '0;
			end
			return 1'b1;
		endfunction

		function void compare_field(string name, logic [ACC_W-1:0] want, logic [ACC_W-1:0] got);
			if (got !== want) begin
				$error("%s expected %0h actual %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_c.size() == 0) begin
				$error("result with nothing expected: row %0h col %0h value %0h",
					got.row, got.col, got.value);
				errors++;
				return;
			end
			want = expected_c.pop_front();
			compare_field("out_row", ACC_W'(want.row), ACC_W'(got.row));
			compare_field("out_col", ACC_W'(want.col), ACC_W'(got.col));
			compare_field("out_value", want.value, got.value);
			compare_field("row_last", ACC_W'(want.last), ACC_W'(got.last));
			compare_field("matrix_done", ACC_W'(want.done), ACC_W'(got.done));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;

	mm_scoreboard sb;
	res_t         seen_c;
	bit           hold_request;
	bit           hold_done;
	bit           steady;
	int           counted;
	int           quiet_cycles;

	matrix_multiply_stream_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_c.row   = m_tdata[ROW_W-1:0];
			seen_c.col   = m_tdata[ROW_W+COL_W-1:ROW_W];
			seen_c.value = m_tdata[ROW_W+COL_W+ACC_W-1:ROW_W+COL_W];
			seen_c.last  = m_tlast;
			seen_c.done  = m_tuser;
			sb.check_result(seen_c);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("matrix_multiply_stream_core verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		m_tready  = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_tready <= steady || ($urandom_range(99) >= 14);
			end
		end
	end

	function automatic logic [ELEM_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return '0;
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	function automatic int pick_row();
		int nr;
		nr = sb.num_rows();
		case ($urandom_range(7))
			0, 1: return nr - 1;
			2: return 0;
			default: return $urandom_range(nr - 1);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_cfg(int hi);
		if ($urandom_range(7) == 0)
			return {(CFG_DATA_W - CNT_W)'($urandom), CNT_W'($urandom_range(hi, 1))};
		return CFG_DATA_W'($urandom_range(hi, 1));
	endfunction

	task automatic send_elem(op_t kind, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
			logic [ELEM_W-1:0] value);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 14) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{S_PAD_W{1'b0}}, value, col, row};
		do
			@(posedge clk);
		while (!s_tready);
		void'(sb.note_element(kind, row, col, value));
		counted++;
	endtask

	task automatic fill_b_row(int k);
		int j;
		for (j = 0; j < sb.num_cols(); j++) begin
			if (!sb.b_written[{DIM_W'(k), DIM_W'(j)}])
				send_elem(OP_B_WRITE, ROW_W'(k), COL_W'(j), pick_value());
		end
	endtask

	task automatic send_row(int i, bit sparse);
		int k, nk;
		nk = sb.num_inner();
		for (k = 0; k < nk; k++) begin
			if (k == nk - 1 || !sparse || $urandom_range(7) == 0) begin
				fill_b_row(k);
				send_elem(OP_A_ELEM, ROW_W'(i), COL_W'(k), pick_value());
			end
		end
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.expected_c.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(logic [CFG_DATA_W-1:0] rows, logic [CFG_DATA_W-1:0] inner,
			logic [CFG_DATA_W-1:0] cols);
		settle();
		cfg_write(REG_ROWS_A, rows);
		cfg_write(REG_INNER_SIZE, inner);
		cfg_write(REG_COLS_B, cols);
	endtask

	task automatic random_phase(int quota);
		int start, r, nr, nk, nc, row, col;
		start = counted;
		nr = sb.num_rows();
		nk = sb.num_inner();
		nc = sb.num_cols();
		while (counted - start < quota) begin
			r = $urandom_range(99);
			if (r < 55) begin
				send_row(pick_row(), nk > 8 || $urandom_range(4) == 0);
			end else if (r < 68) begin
				col = $urandom_range(nk - 1);
				fill_b_row(col);
				send_elem(OP_A_ELEM, ROW_W'(pick_row()), COL_W'(col), pick_value());
			end else if (r < 78) begin
				send_elem(OP_B_WRITE, ROW_W'($urandom_range(nk - 1)),
					COL_W'($urandom_range(nc - 1)), pick_value());
			end else if (r < 89) begin
				if (nr < MAX_ROWS && (nk == MAX_DIM || $urandom_range(1))) begin
					row = $urandom_range(4095, nr);
					col = $urandom_range(63);
					send_elem(OP_A_ELEM, ROW_W'(row), COL_W'(col), pick_value());
				end else if (nk < MAX_DIM) begin
					row = $urandom_range(4095);
					col = $urandom_range(63, nk);
					send_elem(OP_A_ELEM, ROW_W'(row), COL_W'(col), pick_value());
				end
			end else begin
				if (nc < MAX_DIM && $urandom_range(1)) begin
					row = $urandom_range(4095);
					col = $urandom_range(63, nc);
				end else begin
					row = $urandom_range(4095, nk);
					col = $urandom_range(63);
				end
				send_elem(OP_B_WRITE, ROW_W'(row), COL_W'(col), pick_value());
			end
		end
	endtask

	task automatic directed_checks();
		send_elem(OP_B_WRITE, 0, 0, 16'h8000);
		send_elem(OP_B_WRITE, 0, 1, 16'h7FFF);
		send_elem(OP_B_WRITE, 0, 2, 16'h0001);
		send_elem(OP_B_WRITE, 1, 0, 16'h8000);
		send_elem(OP_B_WRITE, 1, 1, 16'hFFFF);
		send_elem(OP_B_WRITE, 1, 2, 16'h7FFF);
		send_elem(OP_A_ELEM, 1, 0, 16'h8000);
		send_elem(OP_A_ELEM, 1, 1, 16'h7FFF);
		send_elem(OP_A_ELEM, 2, 0, 16'h1234);
		send_elem(OP_A_ELEM, 0, 2, 16'h4321);
		send_elem(OP_A_ELEM, 4095, 63, 16'hFFFF);
		send_elem(OP_B_WRITE, 2, 0, 16'h5555);
		send_elem(OP_B_WRITE, 0, 3, 16'hAAAA);
		send_elem(OP_B_WRITE, 4095, 63, 16'hFFFF);
		send_elem(OP_A_ELEM, 0, 0, 16'h7FFF);
		send_elem(OP_A_ELEM, 1, 1, 16'h8000);
		send_elem(OP_A_ELEM, 0, 1, 16'h0100);
		send_elem(OP_A_ELEM, 1, 1, 16'h0000);
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_ROWS_A;
		cfg_data     = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = KIND_B_WRITE;
		hold_request = 1'b0;
		steady       = 1'b0;
		counted      = 0;
		sb = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		configure(2, 2, 3);
		directed_checks();

		configure(0, 1, 1);
		random_phase(20);
		configure(13'h1FFF, 13'h1FFF, 13'h1F80);
		random_phase(25);

		// The output is held off while wide result rows are produced, so the core backs up.
		configure(4096, 0, 64);
		fill_b_row(0);
		hold_request = 1'b1;
		random_phase(30);

		configure(64, 3, 5);
		random_phase(20);
		settle();
		cfg_write(REG_UNMAPPED, CFG_DATA_W'($urandom));

		configure(pick_cfg(8), pick_cfg(6), pick_cfg(8));
		steady = 1'b1;
		random_phase(30);
		steady = 1'b0;

		configure(pick_cfg(8), pick_cfg(6), pick_cfg(8));
		random_phase(15);
		settle();
		random_phase(15);

		while (counted < RANDOM_ITEMS) begin
			configure(pick_cfg(8), pick_cfg(6), pick_cfg(8));
			random_phase(25);
		end

		settle();
		if (sb.errors == 0 && sb.expected_c.size() == 0)
			$display("matrix_multiply_stream_core verification clean");
		else
			$display("matrix_multiply_stream_core verification failed");
		$finish;
	end

endmodule

// ===== matrix_multiply_stream_core.f =====
design/mms_pkg.sv
design/mms_fifo.sv
design/mms_front.sv
design/mms_back.sv
design/matrix_multiply_stream_core.sv
dv/testbench.sv
